// ===== hw/rtl/hslr_pkg.sv =====
package hslr_pkg;

	// Default number of fraction bits of the internal fixed-point format.
	localparam int FracBitsDefault = 16;

	// Restoring divider: quotient bits resolved per pipeline stage.
	localparam int DivStepsPerStage = 4;

	// Largest channel value; fractions are byte / MaxByte.
	localparam int MaxByte = 255;

	// Number of hue sextants.
	localparam int SextantCount = 6;

	// Byte-to-fraction lookup, elaborated once per fraction width.
	typedef logic [63:0] frac_table_t [256];

	// Hue sextant: which channel is at the maximum and which one moves.
	typedef enum logic [2:0] {
		SEXT_RG = 3'd0,
		SEXT_GR = 3'd1,
		SEXT_GB = 3'd2,
		SEXT_BG = 3'd3,
		SEXT_BR = 3'd4,
		SEXT_RB = 3'd5
	} sextant_t;

	// Pipeline depth of one divider.
	function automatic int div_latency(input int frac_bits);
		return (frac_bits + DivStepsPerStage) / DivStepsPerStage;
	endfunction

	// Cycles from an accepted word to its result strobe.
	function automatic int pipe_latency(input int frac_bits);
		return 13 + 2 * div_latency(frac_bits);
	endfunction

	// Table of floor(byte * 2^frac_bits / 255).
	function automatic frac_table_t frac_table(input int frac_bits);
		frac_table_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = (64'(i) << frac_bits) / 64'(MaxByte);
		end
		return tab;
	endfunction

endpackage

// ===== hw/rtl/hsl_hue_rotate.sv =====
// Channel   Direction  Marks a word             Fields
// command   in         start & !busy            in_colour, hue_step
// result    out        done (one cycle)         out_colour
//
// A word is taken on every clock; busy never rises.
// Each result is registered through every stage, including the four-bit-per-stage restoring dividers:
// saturation and hue side by side, then chroma over value.
// Reset clears the valid bits only; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module hsl_hue_rotate #(
	parameter int FRAC_BITS = hslr_pkg::FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        in_colour,
	input  logic signed [31:0] hue_step,
	output logic               done,
	output logic [31:0]        out_colour
);
	import hslr_pkg::*;

	localparam int QW = FRAC_BITS + 3;
	localparam int DL = div_latency(FRAC_BITS);
	localparam int K6 = QW + 3;
	localparam int PW = K6 + QW;
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << K6) + 64'd5) / 64'd6;
	localparam logic [QW:0] RECIP6 = RECIP_WIDE[QW:0];
	localparam frac_table_t FRAC_TAB = frac_table(FRAC_BITS);
	localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);
	localparam logic [QW-1:0] TWO_Q  = QW'(2) << FRAC_BITS;

	typedef struct packed {
		logic [31:0]    pix;
		logic [7:0]     step;
		logic           byp;
		logic [QW-1:0]  l;
		logic [2:0]     hbase;
		logic           hneg;
		logic           flat;
		logic           black;
	} fwd_ctx_t;

	typedef struct packed {
		logic [31:0]          pix;
		logic                 byp;
		logic [QW-1:0]        l;
		logic [QW-1:0]        v;
		logic [QW-1:0]        m;
		sextant_t             sx;
		logic [FRAC_BITS-1:0] frac;
		logic                 vzero;
	} back_ctx_t;

	function automatic logic [QW-1:0] frac_of(input logic [7:0] value);
		logic [63:0] e;
		e = FRAC_TAB[value];
		return e[QW-1:0];
	endfunction

	// floor(0.5 + x * 255), kept to eight bits.
	function automatic logic [7:0] to_byte(input logic [QW-1:0] x);
		logic [QW+8:0] t;
		t = ({9'd0, x} << 8) - {9'd0, x} + {9'd0, HALF_Q};
		return t[FRAC_BITS +: 8];
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: channel bytes to fractions.
	logic          vld_s1, byp_s1;
	logic [31:0]   pix_s1;
	logic [7:0]    step_s1;
	logic [QW-1:0] r_s1, g_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= in_colour;
		step_s1 <= hue_step[7:0];
		byp_s1  <= (hue_step == '0);
		r_s1    <= frac_of(in_colour[31:24]);
		g_s1    <= frac_of(in_colour[23:16]);
		b_s1    <= frac_of(in_colour[15:8]);
	end

	// Stage 2: maximum and minimum channel.
	logic          vld_s2, byp_s2;
	logic [31:0]   pix_s2;
	logic [7:0]    step_s2;
	logic [QW-1:0] r_s2, g_s2, b_s2, v_s2, m_s2;
	logic [QW-1:0] v_rg, m_rg;

	assign v_rg = (r_s1 > g_s1) ? r_s1 : g_s1;
	assign m_rg = (r_s1 < g_s1) ? r_s1 : g_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s2  <= pix_s1;
		step_s2 <= step_s1;
		byp_s2  <= byp_s1;
		r_s2    <= r_s1;
		g_s2    <= g_s1;
		b_s2    <= b_s1;
		v_s2    <= (b_s1 > v_rg) ? b_s1 : v_rg;
		m_s2    <= (b_s1 < m_rg) ? b_s1 : m_rg;
	end

	// Stage 3: lightness, saturation divisor and hue numerator.
	logic          vld_s3;
	fwd_ctx_t      ctx_s3;
	logic [QW-1:0] vm_s3, den_s3, hnum_s3;
	logic [QW:0]   sum_vm;
	logic [QW-1:0] l_c, vm_c, den_c, hnum_c;
	logic [2:0]    hbase_c;
	logic          hneg_c;

	always_comb begin
		sum_vm = {1'b0, v_s2} + {1'b0, m_s2};
		l_c    = sum_vm[QW:1];
		vm_c   = v_s2 - m_s2;
		den_c  = (l_c <= HALF_Q) ? (v_s2 + m_s2) : (TWO_Q - v_s2 - m_s2);
		priority if (r_s2 == v_s2) begin
			if (g_s2 == m_s2) begin
				hbase_c = 3'd5; hneg_c = 1'b0; hnum_c = v_s2 - b_s2;
			end else begin
				hbase_c = 3'd1; hneg_c = 1'b1; hnum_c = v_s2 - g_s2;
			end
		end else if (g_s2 == v_s2) begin
			if (b_s2 == m_s2) begin
				hbase_c = 3'd1; hneg_c = 1'b0; hnum_c = v_s2 - r_s2;
			end else begin
				hbase_c = 3'd3; hneg_c = 1'b1; hnum_c = v_s2 - b_s2;
			end
		end else begin
			if (r_s2 == m_s2) begin
				hbase_c = 3'd3; hneg_c = 1'b0; hnum_c = v_s2 - g_s2;
			end else begin
				hbase_c = 3'd5; hneg_c = 1'b1; hnum_c = v_s2 - r_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3.pix   <= pix_s2;
		ctx_s3.step  <= step_s2;
		ctx_s3.byp   <= byp_s2;
		ctx_s3.l     <= l_c;
		ctx_s3.hbase <= hbase_c;
		ctx_s3.hneg  <= hneg_c;
		ctx_s3.black <= (l_c == '0);
		ctx_s3.flat  <= (l_c == '0) || (vm_c == '0);
		vm_s3        <= vm_c;
		den_s3       <= den_c;
		hnum_s3      <= hnum_c;
	end

	// Saturation and hue fraction dividers, with the context alongside.
	logic [QW-1:0] sat_q, hq_q;
	logic [DL-1:0] fvld_d;
	fwd_ctx_t      fctx_d [DL];

	hslr_div #(.FRAC_BITS(FRAC_BITS), .WIDTH(QW)) u_div_sat (
		.clk      (clk),
		.dividend (vm_s3),
		.divisor  (den_s3),
		.quotient (sat_q)
	);

	hslr_div #(.FRAC_BITS(FRAC_BITS), .WIDTH(QW)) u_div_hue (
		.clk      (clk),
		.dividend (hnum_s3),
		.divisor  (vm_s3),
		.quotient (hq_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_d <= '0;
		end else begin
			fvld_d <= {fvld_d[DL-2:0], vld_s3};
		end
	end

	always_ff @(posedge clk) begin
		fctx_d[0] <= ctx_s3;
		for (int i = 1; i < DL; i++) begin
			fctx_d[i] <= fctx_d[i-1];
		end
	end

	// Stage 4: hue in sixths of a turn.
	logic          vld_s4;
	fwd_ctx_t      ctx_s4;
	logic [QW-1:0] h_s4, s_s4, hbase_q;

	assign hbase_q = QW'(fctx_d[DL-1].hbase) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= fvld_d[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		ctx_s4 <= fctx_d[DL-1];
		s_s4   <= sat_q;
		h_s4   <= fctx_d[DL-1].hneg ? (hbase_q - hq_q) : (hbase_q + hq_q);
	end

	// Stage 5: hue divided by six through a reciprocal product.
	logic          vld_s5;
	fwd_ctx_t      ctx_s5;
	logic [QW-1:0] h_s5, s_s5;
	logic [PW-1:0] h6_prod;

	assign h6_prod = PW'(h_s4) * PW'(RECIP6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s5 <= ctx_s4;
		s_s5   <= s_s4;
		h_s5   <= h6_prod[K6 +: QW];
	end

	// Stage 6: HSL bytes and the hue step.
	logic        vld_s6, byp_s6;
	logic [31:0] pix_s6;
	logic [7:0]  hb_s6, sb_s6, lb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		pix_s6 <= ctx_s5.pix;
		byp_s6 <= ctx_s5.byp;
		hb_s6  <= (ctx_s5.flat ? 8'd0 : to_byte(h_s5)) + ctx_s5.step;
		sb_s6  <= ctx_s5.flat ? 8'd0 : to_byte(s_s5);
		lb_s6  <= ctx_s5.black ? 8'd0 : to_byte(ctx_s5.l);
	end

	// Stage 7: HSL bytes back to fractions.
	logic          vld_s7, byp_s7;
	logic [31:0]   pix_s7;
	logic [QW-1:0] hf_s7, sf_s7, lf_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		pix_s7 <= pix_s6;
		byp_s7 <= byp_s6;
		hf_s7  <= frac_of(hb_s6);
		sf_s7  <= frac_of(sb_s6);
		lf_s7  <= frac_of(lb_s6);
	end

	// Stage 8: lightness times saturation, and hue times six.
	logic            vld_s8, byp_s8;
	logic [31:0]     pix_s8;
	logic [QW-1:0]   p_s8, h6_s8, sf_s8, lf_s8;
	logic [2*QW-1:0] ls_prod;

	assign ls_prod = (2*QW)'(lf_s7) * (2*QW)'(sf_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		pix_s8 <= pix_s7;
		byp_s8 <= byp_s7;
		sf_s8  <= sf_s7;
		lf_s8  <= lf_s7;
		p_s8   <= ls_prod[FRAC_BITS +: QW];
		h6_s8  <= (hf_s7 << 2) + (hf_s7 << 1);
	end

	// Stage 9: the value channel.
	logic          vld_s9, byp_s9;
	logic [31:0]   pix_s9;
	logic [QW-1:0] v_s9, lf_s9, h6_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		pix_s9 <= pix_s8;
		byp_s9 <= byp_s8;
		lf_s9  <= lf_s8;
		h6_s9  <= h6_s8;
		v_s9   <= (lf_s8 <= HALF_Q) ? (lf_s8 + p_s8) : (lf_s8 + sf_s8 - p_s8);
	end

	// Stage 10: minimum channel, sextant and divider operands.
	logic          vld_s10;
	back_ctx_t     ctx_s10;
	logic [QW-1:0] num_s10;
	logic [QW-1:0] two_l, m_c;
	logic [2:0]    sext_raw;
	sextant_t      sx_c;

	always_comb begin
		two_l    = lf_s9 << 1;
		m_c      = (two_l >= v_s9) ? (two_l - v_s9) : '0;
		sext_raw = h6_s9[FRAC_BITS +: 3];
		sx_c     = (sext_raw >= 3'(SextantCount)) ? SEXT_RG : sextant_t'(sext_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s10.pix   <= pix_s9;
		ctx_s10.byp   <= byp_s9;
		ctx_s10.l     <= lf_s9;
		ctx_s10.v     <= v_s9;
		ctx_s10.m     <= m_c;
		ctx_s10.sx    <= sx_c;
		ctx_s10.frac  <= h6_s9[FRAC_BITS-1:0];
		ctx_s10.vzero <= (v_s9 == '0);
		num_s10       <= (v_s9 >= m_c) ? (v_s9 - m_c) : '0;
	end

	// Chroma-over-value divider, with the context alongside.
	logic [QW-1:0] sv_q;
	logic [DL-1:0] bvld_d;
	back_ctx_t     bctx_d [DL];

	hslr_div #(.FRAC_BITS(FRAC_BITS), .WIDTH(QW)) u_div_sv (
		.clk      (clk),
		.dividend (num_s10),
		.divisor  (ctx_s10.v),
		.quotient (sv_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_d <= '0;
		end else begin
			bvld_d <= {bvld_d[DL-2:0], vld_s10};
		end
	end

	always_ff @(posedge clk) begin
		bctx_d[0] <= ctx_s10;
		for (int i = 1; i < DL; i++) begin
			bctx_d[i] <= bctx_d[i-1];
		end
	end

	// Stage 11: value times the chroma ratio.
	logic            vld_s11;
	back_ctx_t       ctx_s11;
	logic [QW-1:0]   t_s11;
	logic [2*QW-1:0] vs_prod;

	assign vs_prod = (2*QW)'(bctx_d[DL-1].v) * (2*QW)'(sv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else begin
			vld_s11 <= bvld_d[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		ctx_s11 <= bctx_d[DL-1];
		t_s11   <= vs_prod[FRAC_BITS +: QW];
	end

	// Stage 12: scaled by the position inside the sextant.
	logic                    vld_s12;
	back_ctx_t               ctx_s12;
	logic [QW-1:0]           vsf_s12;
	logic [QW+FRAC_BITS-1:0] vsf_prod;

	assign vsf_prod = (QW+FRAC_BITS)'(t_s11) * (QW+FRAC_BITS)'(ctx_s11.frac);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s12 <= ctx_s11;
		vsf_s12 <= vsf_prod[FRAC_BITS +: QW];
	end

	// Stage 13: channel selection per sextant, output register.
	logic [QW-1:0] mid1, mid2, rc, gc, bc;

	always_comb begin
		mid1 = ctx_s12.m + vsf_s12;
		mid2 = (ctx_s12.v >= vsf_s12) ? (ctx_s12.v - vsf_s12) : '0;
		unique case (ctx_s12.sx)
			SEXT_RG: begin rc = ctx_s12.v; gc = mid1;      bc = ctx_s12.m; end
			SEXT_GR: begin rc = mid2;      gc = ctx_s12.v; bc = ctx_s12.m; end
			SEXT_GB: begin rc = ctx_s12.m; gc = ctx_s12.v; bc = mid1;      end
			SEXT_BG: begin rc = ctx_s12.m; gc = mid2;      bc = ctx_s12.v; end
			SEXT_BR: begin rc = mid1;      gc = ctx_s12.m; bc = ctx_s12.v; end
			SEXT_RB: begin rc = ctx_s12.v; gc = ctx_s12.m; bc = mid2;      end
			default: begin rc = ctx_s12.v; gc = ctx_s12.m; bc = mid2;      end
		endcase
		if (ctx_s12.vzero) begin
			rc = ctx_s12.l;
			gc = ctx_s12.l;
			bc = ctx_s12.l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		out_colour <= ctx_s12.byp ? ctx_s12.pix
			: {to_byte(rc), to_byte(gc), to_byte(bc), ctx_s12.pix[7:0]};
	end

endmodule

// ===== hw/rtl/hslr_div.sv =====
module hslr_div #(
	parameter int FRAC_BITS = hslr_pkg::FracBitsDefault,
	parameter int WIDTH     = hslr_pkg::FracBitsDefault + 3
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient
);
	import hslr_pkg::*;

	localparam int Stages = div_latency(FRAC_BITS);
	localparam int Steps  = FRAC_BITS + 1;

	logic [WIDTH:0]   rem_in [Stages];
	logic [WIDTH-1:0] quo_in [Stages];
	logic [WIDTH-1:0] den_in [Stages];
	logic [WIDTH:0]   rem_s  [Stages];
	logic [WIDTH-1:0] quo_s  [Stages];
	logic [WIDTH-1:0] den_s  [Stages];

	// Each stage resolves a few quotient bits: the integer bit first, then fraction bits.
	for (genvar k = 0; k < Stages; k++) begin : g_stage
		logic [WIDTH:0]   rem_nx;
		logic [WIDTH-1:0] quo_nx;

		if (k == 0) begin : g_head
			assign rem_in[k] = {1'b0, dividend};
			assign quo_in[k] = '0;
			assign den_in[k] = divisor;
		end else begin : g_tail
			assign rem_in[k] = rem_s[k-1];
			assign quo_in[k] = quo_s[k-1];
			assign den_in[k] = den_s[k-1];
		end

		always_comb begin
			rem_nx = rem_in[k];
			quo_nx = quo_in[k];
			for (int j = 0; j < DivStepsPerStage; j++) begin
				if (k * DivStepsPerStage + j < Steps) begin
					if (k * DivStepsPerStage + j != 0) begin
						rem_nx = rem_nx << 1;
					end
					quo_nx = quo_nx << 1;
					if (rem_nx >= {1'b0, den_in[k]}) begin
						rem_nx    = rem_nx - {1'b0, den_in[k]};
						quo_nx[0] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			quo_s[k] <= quo_nx;
			den_s[k] <= den_in[k];
		end
	end

	// A zero divisor gives a zero quotient.
	assign quotient = (den_s[Stages-1] == '0) ? '0 : quo_s[Stages-1];

endmodule

// ===== hw/rtl/hslr_check.sv =====
module hslr_check #(
	parameter int FRAC_BITS = hslr_pkg::FracBitsDefault
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [31:0]        in_colour,
	input logic signed [31:0] hue_step,
	input logic               done,
	input logic [31:0]        out_colour
);
	import hslr_pkg::*;

	localparam int Lat = pipe_latency(FRAC_BITS);

	// Every accepted word produces its result strobe after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Lat done)
		else $error("accepted word produced no result");

	// No result strobe appears without an accepted word behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Lat))
		else $error("result strobe without an accepted word");

	// A zero hue step returns the pixel unchanged.
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && hue_step == 0) |-> ##Lat (out_colour == $past(in_colour, Lat)))
		else $error("bypassed pixel changed");

	// Alpha always travels through untouched.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Lat (out_colour[7:0] == $past(in_colour[7:0], Lat)))
		else $error("alpha changed");

endmodule

bind hsl_hue_rotate hslr_check #(.FRAC_BITS(FRAC_BITS)) u_hslr_check (.*);
